[sv/pfpd_pkg.sv]
// pfpd_pkg: shared types and constants of the person-follow PD controller.
// No dependencies; imported by every module of the block.
package pfpd_pkg;

    // Register map, index = paddr[4:2]
    typedef enum logic [2:0] {
        REG_FOLLOW_ENABLE   = 3'd0,
        REG_TARGET_BEARING  = 3'd1,
        REG_TARGET_RANGE_MM = 3'd2,
        REG_LIN_P_GAIN      = 3'd3,
        REG_LIN_D_GAIN      = 3'd4,
        REG_ANG_P_GAIN      = 3'd5,
        REG_ANG_D_GAIN      = 3'd6
    } pfpd_reg_t;

    localparam logic [13:0] TARGET_RANGE_RST = 14'd2000;
    localparam logic [31:0] GAIN_RST         = 32'd655;

    // 0.01 in Q3.12 and the open 80 mm band
    localparam int BEARING_DEADBAND = 40;
    localparam int RANGE_DEADBAND   = 79;

    // /16000 = >>7 then /125; the /125 is exact for 18-bit operands as
    // (n * 134218) >> 24
    localparam int          LIN_SHIFT       = 7;
    localparam logic [17:0] LIN_RECIP       = 18'd134218;
    localparam int          LIN_RECIP_SHIFT = 24;
    // |lin sum| at or above 2048*16000 clamps
    localparam logic [49:0] LIN_CLAMP_MAG = 50'd32768000;
    // |ang sum| at or above 4096*65536 clamps
    localparam logic [49:0] ANG_CLAMP_MAG = 50'd268435456;

    localparam int DIVB_STEPS = 15;
    localparam int MUL_STEPS  = 5;

    typedef struct packed {
        logic        follow_enable;
        logic [15:0] target_bearing;
        logic [13:0] target_range_mm;
        logic [31:0] lin_p_gain;
        logic [31:0] lin_d_gain;
        logic [31:0] ang_p_gain;
        logic [31:0] ang_d_gain;
    } pfpd_cfg_t;

    // controller -> datapath commands
    typedef struct packed {
        logic       load;
        logic       prep;
        logic       div_step;
        logic       err;
        logic       mul;
        logic [2:0] mul_idx;
        logic       scale;
        logic       recip;
        logic       commit;
    } pfpd_cmd_t;

endpackage

[sv/pfpd_cfg.sv]
// pfpd_cfg: APB-style register file of the controller.
// Depends on pfpd_pkg for the register map and the config struct.
module pfpd_cfg
    import pfpd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output pfpd_cfg_t   cfg
);

    pfpd_cfg_t cfg_reg, cfg_next;
    pfpd_reg_t idx;
    logic      wr_en;

    assign pready = 1'b1;
    assign idx    = pfpd_reg_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                REG_FOLLOW_ENABLE:   cfg_next.follow_enable   = pwdata[0];
                REG_TARGET_BEARING:  cfg_next.target_bearing  = pwdata[15:0];
                REG_TARGET_RANGE_MM: cfg_next.target_range_mm = pwdata[13:0];
                REG_LIN_P_GAIN:      cfg_next.lin_p_gain      = pwdata;
                REG_LIN_D_GAIN:      cfg_next.lin_d_gain      = pwdata;
                REG_ANG_P_GAIN:      cfg_next.ang_p_gain      = pwdata;
                REG_ANG_D_GAIN:      cfg_next.ang_d_gain      = pwdata;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_FOLLOW_ENABLE:   prdata = {31'b0, cfg_reg.follow_enable};
            REG_TARGET_BEARING:  prdata = {{16{cfg_reg.target_bearing[15]}},
                                           cfg_reg.target_bearing};
            REG_TARGET_RANGE_MM: prdata = {18'b0, cfg_reg.target_range_mm};
            REG_LIN_P_GAIN:      prdata = cfg_reg.lin_p_gain;
            REG_LIN_D_GAIN:      prdata = cfg_reg.lin_d_gain;
            REG_ANG_P_GAIN:      prdata = cfg_reg.ang_p_gain;
            REG_ANG_D_GAIN:      prdata = cfg_reg.ang_d_gain;
            default:             prdata = 32'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.follow_enable   <= 1'b1;
            cfg_reg.target_bearing  <= 16'd0;
            cfg_reg.target_range_mm <= TARGET_RANGE_RST;
            cfg_reg.lin_p_gain      <= GAIN_RST;
            cfg_reg.lin_d_gain      <= GAIN_RST;
            cfg_reg.ang_p_gain      <= GAIN_RST;
            cfg_reg.ang_d_gain      <= GAIN_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[sv/pfpd_ctrl.sv]
// pfpd_ctrl: sequencer of the controller; drives the datapath commands
// and the stream handshakes. Depends on pfpd_pkg.
module pfpd_ctrl
    import pfpd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      follow_enable,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    output pfpd_cmd_t cmd
);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_PREP  = 8'b0000_0010,
        ST_DIVB  = 8'b0000_0100,
        ST_ERR   = 8'b0000_1000,
        ST_MUL   = 8'b0001_0000,
        ST_SCALE = 8'b0010_0000,
        ST_RECIP = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } state_t;

    state_t     state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;
    logic       m_valid_reg, m_valid_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                // disabled: request is taken and dropped
                if (s_tvalid && follow_enable) begin
                    cmd.load   = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                cnt_next   = 4'd0;
                state_next = ST_DIVB;
            end
            ST_DIVB: begin
                cmd.div_step = 1'b1;
                if (cnt_reg == 4'(DIVB_STEPS - 1)) begin
                    cnt_next   = 4'd0;
                    state_next = ST_ERR;
                end else begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end
            ST_ERR: begin
                cmd.err    = 1'b1;
                cnt_next   = 4'd0;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul     = 1'b1;
                cmd.mul_idx = cnt_reg[2:0];
                if (cnt_reg == 4'(MUL_STEPS - 1)) begin
                    cnt_next   = 4'd0;
                    state_next = ST_SCALE;
                end else begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end
            ST_SCALE: begin
                cmd.scale  = 1'b1;
                cnt_next   = 4'd0;
                state_next = ST_RECIP;
            end
            ST_RECIP: begin
                // /125 by reciprocal multiply
                cmd.recip  = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // wait for a free output slot
                if (!m_valid_reg || m_tready) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
                cnt_next   = 4'd0;
            end
        endcase
    end

    always_comb begin
        if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= 4'd0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // stalled result keeps the sequencer parked
    a_done_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && m_valid_reg && !m_tready) |=> (state_reg == ST_DONE))
        else $error("pfpd_ctrl: left DONE while output slot busy");

    a_disabled_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !follow_enable) |=> (state_reg == ST_IDLE && !cmd.commit))
        else $error("pfpd_ctrl: request processed while following disabled");

    a_idle_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (cnt_reg == 4'd0))
        else $error("pfpd_ctrl: step counter not cleared at idle");

endmodule

[sv/pfpd_dp.sv]
// pfpd_dp: datapath of the controller: serial divider, shared multiplier,
// error/deadband logic, scaling, clamps and output register. Depends on pfpd_pkg.
module pfpd_dp
    import pfpd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  pfpd_cmd_t   cmd,
    input  pfpd_cfg_t   cfg,
    input  logic [47:0] s_tdata,
    output logic [26:0] out_data
);

    // input latch
    logic signed [15:0] x_reg;
    logic signed [15:0] y_reg;
    logic [13:0]        z_reg;

    // case flags
    logic allzero_reg, zzero_reg, sat_reg, xneg_reg, xzero_reg;

    // serial restoring divider
    logic [13:0] rem_reg, rem_next;
    logic [14:0] dvd_reg, dvd_next;
    logic [14:0] quo_reg, quo_next;
    logic [13:0] div_reg, div_next;
    logic [14:0] r2;
    logic        ge;

    // errors and PD state
    logic signed [16:0] eb_reg, prev_b_reg;
    logic signed [15:0] er_reg, prev_r_reg;

    // multiply / accumulate
    logic signed [17:0] opa;
    logic signed [31:0] opb;
    logic signed [49:0] prod_reg, prod_next;
    logic signed [49:0] lin_acc_reg, ang_acc_reg;

    // scaling
    logic        lin_neg_reg, lin_clamp_reg;
    logic [17:0] lin_red_reg;
    logic [10:0] lin_q_reg;
    logic [13:0] ang_reg;
    logic [26:0] out_reg;

    logic [15:0] absx;
    logic        sat;
    logic signed [15:0] bearing;
    logic [13:0] range_mm;
    logic signed [16:0] eb_raw, eb_next;
    logic signed [15:0] er_raw, er_next;
    logic [49:0] lin_mag, ang_mag;
    logic [17:0] lin_red;
    logic [35:0] lin_prod;
    logic [12:0] ang_m;
    logic [13:0] ang_next;
    logic [11:0] lin_m;
    logic [12:0] lin_out;

    assign out_data = out_reg;

    // prep: |x|, saturation test |x| >= 8z
    assign absx = x_reg[15] ? 16'(-x_reg) : x_reg;
    assign sat  = ({1'b0, absx} >= {z_reg, 3'b000});

    // scale
    assign lin_mag = lin_acc_reg[49] ? 50'(-lin_acc_reg) : lin_acc_reg;
    assign ang_mag = ang_acc_reg[49] ? 50'(-ang_acc_reg) : ang_acc_reg;
    assign lin_red = lin_mag[LIN_SHIFT +: 18];
    assign ang_m   = (ang_mag >= ANG_CLAMP_MAG) ? 13'd4096 : {1'b0, ang_mag[27:16]};
    assign ang_next = ang_acc_reg[49] ? 14'(-{1'b0, ang_m}) : {1'b0, ang_m};

    // floor(lin_red / 125), exact below the clamp
    assign lin_prod = lin_red_reg * LIN_RECIP;

    // divider step and loads
    assign r2 = {rem_reg, dvd_reg[14]};
    assign ge = (r2 >= {1'b0, div_reg});

    always_comb begin
        rem_next = rem_reg;
        dvd_next = dvd_reg;
        quo_next = quo_reg;
        div_next = div_reg;
        if (cmd.prep) begin
            // quotient < 2^15 when not saturated, so top remainder is < z
            rem_next = {1'b0, absx[15:3]};
            dvd_next = {absx[2:0], 12'b0};
            quo_next = 15'd0;
            div_next = z_reg;
        end else if (cmd.div_step) begin
            rem_next = ge ? 14'(r2 - {1'b0, div_reg}) : r2[13:0];
            dvd_next = {dvd_reg[13:0], 1'b0};
            quo_next = {quo_reg[13:0], ge};
        end
    end

    // bearing, range, errors with deadbands
    always_comb begin
        priority if (allzero_reg) begin
            bearing = cfg.target_bearing;
        end else if (zzero_reg || sat_reg) begin
            bearing = xneg_reg ? -16'sd32768 : (xzero_reg ? 16'sd0 : 16'sd32767);
        end else begin
            bearing = xneg_reg ? 16'(-{1'b0, quo_reg}) : {1'b0, quo_reg};
        end
        range_mm = allzero_reg ? cfg.target_range_mm : z_reg;
        eb_raw = {bearing[15], bearing}
               - {cfg.target_bearing[15], cfg.target_bearing};
        er_raw = {2'b00, range_mm} - {2'b00, cfg.target_range_mm};
        eb_next = (eb_raw >= -17'(BEARING_DEADBAND) && eb_raw <= 17'(BEARING_DEADBAND))
                ? 17'sd0 : eb_raw;
        er_next = (er_raw >= -16'(RANGE_DEADBAND) && er_raw <= 16'(RANGE_DEADBAND))
                ? 16'sd0 : er_raw;
    end

    // shared multiplier operands
    always_comb begin
        unique case (cmd.mul_idx)
            3'd0: begin
                opa = {{2{er_reg[15]}}, er_reg};
                opb = cfg.lin_p_gain;
            end
            3'd1: begin
                opa = {{2{er_reg[15]}}, er_reg} - {{2{prev_r_reg[15]}}, prev_r_reg};
                opb = cfg.lin_d_gain;
            end
            3'd2: begin
                opa = {eb_reg[16], eb_reg};
                opb = cfg.ang_p_gain;
            end
            3'd3: begin
                opa = {eb_reg[16], eb_reg} - {prev_b_reg[16], prev_b_reg};
                opb = cfg.ang_d_gain;
            end
            default: begin
                opa = 18'sd0;
                opb = 32'sd0;
            end
        endcase
        prod_next = opa * opb;
    end

    // linear result from the reciprocal quotient
    assign lin_m   = lin_clamp_reg ? 12'd2048 : {1'b0, lin_q_reg};
    assign lin_out = lin_neg_reg ? 13'(-{1'b0, lin_m}) : {1'b0, lin_m};

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            x_reg <= s_tdata[15:0];
            y_reg <= s_tdata[31:16];
            z_reg <= s_tdata[45:32];
        end
        if (cmd.prep) begin
            allzero_reg <= (x_reg == 16'sd0) && (y_reg == 16'sd0) && (z_reg == 14'd0);
            zzero_reg   <= (z_reg == 14'd0);
            sat_reg     <= sat;
            xneg_reg    <= x_reg[15];
            xzero_reg   <= (x_reg == 16'sd0);
        end
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
        if (cmd.err) begin
            eb_reg <= eb_next;
            er_reg <= er_next;
        end
        if (cmd.mul) begin
            prod_reg <= prod_next;
            unique case (cmd.mul_idx)
                3'd1:    lin_acc_reg <= prod_reg;
                3'd2:    lin_acc_reg <= lin_acc_reg + prod_reg;
                3'd3:    ang_acc_reg <= prod_reg;
                3'd4:    ang_acc_reg <= ang_acc_reg + prod_reg;
                default: ;
            endcase
        end
        if (cmd.scale) begin
            lin_neg_reg   <= lin_acc_reg[49];
            lin_clamp_reg <= (lin_mag >= LIN_CLAMP_MAG);
            lin_red_reg   <= lin_red;
            ang_reg       <= ang_next;
        end
        if (cmd.recip) begin
            lin_q_reg <= lin_prod[LIN_RECIP_SHIFT +: 11];
        end
        if (cmd.commit) begin
            out_reg <= {ang_reg, lin_out};
        end
    end

    // PD history: cleared by reset, updated only on a delivered result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_b_reg <= 17'sd0;
            prev_r_reg <= 16'sd0;
        end else if (cmd.commit) begin
            prev_b_reg <= eb_reg;
            prev_r_reg <= er_reg;
        end
    end

    a_lin_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> ($signed(out_reg[12:0]) <= 13'sd2048
                        && $signed(out_reg[12:0]) >= -13'sd2048))
        else $error("pfpd_dp: linear command outside clamp");

    a_eb_deadband: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.err |=> (eb_reg == 17'sd0 || eb_reg > 17'sd40 || eb_reg < -17'sd40))
        else $error("pfpd_dp: bearing error inside deadband not zeroed");

endmodule

[sv/person_follow_pd_controller.sv]
// person_follow_pd_controller: top level of the person-follow PD controller.
// Depends on pfpd_pkg, pfpd_cfg, pfpd_ctrl and pfpd_dp.
//
// Usage:
//   s_ channel carries one body position request per sample (x, y, z in mm).
//   m_ channel returns one velocity command pair per request while following
//   is enabled; with follow_enable = 0 requests are taken and dropped and the
//   PD history stays untouched.
//   APB-style port holds targets, gains and the enable (register i at 4*i);
//   write it only while the block is idle.
// Sequence:
//   A request is taken only when the sequencer is idle, so a new request waits
//   until the last result is committed. Each request runs through prep, the
//   15-step serial divider pass (bearing x/z), error, the shared multiplier
//   pass, scale, reciprocal and done; the /125 of the linear law is one
//   reciprocal multiply.
// Reset (aresetn low, synchronous): config registers return to their defaults,
//   PD history clears, the output register empties.
// Stall: the result sits in the output register; the sequencer finishes the
//   next item and holds it until the register frees up.
module person_follow_pd_controller
    import pfpd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // request in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [15:0] com_x, [31:16] com_y, [45:32] com_z, rest 0
    // command out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [12:0] linear_velocity, [26:13] angular_velocity
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    pfpd_cfg_t   cfg;
    pfpd_cmd_t   cmd;
    logic [26:0] out_data;

    pfpd_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer: handshakes plus per-step commands
    pfpd_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .follow_enable (cfg.follow_enable),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .cmd           (cmd)
    );

    // arithmetic and the output register
    pfpd_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .cfg      (cfg),
        .s_tdata  (s_tdata),
        .out_data (out_data)
    );

    assign m_tdata = {5'b0, out_data};

endmodule
